FILE: sv/djs_pkg.sv
package djs_pkg;

  // Field widths fixed by the request format.
  localparam int DL_W     = 8;
  localparam int PROFIT_W = 16;
  localparam int ENTRY_W  = DL_W + PROFIT_W;
  localparam int COUNT_W  = 8;
  localparam int SUM_W    = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // One stored job: deadline above profit.
  typedef struct packed {
    logic [DL_W-1:0]     deadline;
    logic [PROFIT_W-1:0] profit;
  } job_t;

endpackage

FILE: sv/djs_job_mem.sv
// Job store: one write port, one registered read port.
module djs_job_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  djs_pkg::job_t wr_data,
  input  logic [AW-1:0] rd_addr,
  output djs_pkg::job_t rd_data
);
  import djs_pkg::*;

  job_t mem [DEPTH];
  job_t rd_data_r;

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/djs_slot_mem.sv
// Slot occupancy map: one taken bit per slot, one write port, one registered read port.
module djs_slot_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_taken,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_taken
);
  logic mem [DEPTH];
  logic rd_taken_r;

  // Synchronous write and read; the scheduler clears the map before each run.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_taken;
    end
    rd_taken_r <= mem[rd_addr];
  end

  assign rd_taken = rd_taken_r;

endmodule

FILE: sv/deadline_job_scheduler_unit.sv
// Greedy job sequencing with deadlines.
// Input channel: one job request per accepted cycle (deadline, job_profit, last).
// Unless stalled, jobs load at one per cycle into a job store of MAX_JOBS
// entries; jobs beyond that are discarded and reported through out_dropped.
// A request with last set closes the set (its job is stored if room remains)
// and starts the schedule. A run first clears all MAX_DEADLINE+1 entries of
// the slot map, one entry per cycle. It then picks jobs by falling profit:
// each pick scans the whole store for the largest (profit, index) key below
// the previous pick, one read per cycle through the single read port of the
// job store. The slot walk then goes down from the job's deadline to slot 1,
// checking one slot at a time, and places the job in the first free slot.
// One result request (count, total profit, dropped) follows each set and is held
// in an output register until out_stall is low. The input is stalled from the
// last request until the result enters that register; the next set may load
// while the result waits.
// Reset (rst_n low, synchronous) empties the store and drops any result.
module deadline_job_scheduler_unit #(
  parameter int MAX_JOBS     = 256,
  parameter int MAX_DEADLINE = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [djs_pkg::DL_W-1:0]    in_deadline,
  input  logic [djs_pkg::PROFIT_W-1:0] in_job_profit,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [djs_pkg::COUNT_W-1:0] out_scheduled_count,
  output logic [djs_pkg::SUM_W-1:0]   out_total_profit,
  output logic                        out_dropped
);
  import djs_pkg::*;

  localparam int JAW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int FW  = $clog2(MAX_JOBS + 1);
  localparam int SAW = $clog2(MAX_DEADLINE + 1);
  localparam int SDEPTH = MAX_DEADLINE + 1;
  localparam int KEY_W = PROFIT_W + JAW;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_SLOT = 3'd3;
  localparam logic [2:0] ST_SCHK = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;
  localparam logic [2:0] ST_CLR  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               ovf_r, ovf_nxt;
  logic               drop_r, drop_nxt;      // dropped flag of the running set
  logic               lim_ok_r, lim_ok_nxt;  // a previous pick bounds the scan
  logic [KEY_W-1:0]   lim_r, lim_nxt;        // key of the previous pick
  logic [FW-1:0]      scan_r, scan_nxt;      // next address issued
  logic [FW-1:0]      picks_r, picks_nxt;    // jobs processed this run
  logic               rvld_r, rvld_nxt;      // read data valid this cycle
  logic [JAW-1:0]     raddr_r, raddr_nxt;    // address of read data
  logic               best_ok_r, best_ok_nxt;
  logic [JAW-1:0]     best_idx_r, best_idx_nxt;
  job_t               best_r, best_nxt;
  logic [SAW-1:0]     slot_r, slot_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               ovld_r, ovld_nxt;
  logic [COUNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [SUM_W-1:0]   osum_r, osum_nxt;
  logic               odrop_r, odrop_nxt;

  logic          jw_en;
  logic [JAW-1:0] jw_addr, jr_addr;
  job_t          jw_data, jr_data;
  logic          sw_en, sw_taken, s_rd_taken;
  logic [SAW-1:0] s_rd_addr;
  logic          in_acc;
  logic [DL_W-1:0] dl_sat;
  logic [KEY_W-1:0] rkey, bkey;

  djs_job_mem #(.DEPTH(MAX_JOBS), .AW(JAW)) u_jobs (
    .clk, .wr_en(jw_en), .wr_addr(jw_addr), .wr_data(jw_data),
    .rd_addr(jr_addr), .rd_data(jr_data)
  );

  djs_slot_mem #(.DEPTH(SDEPTH), .AW(SAW)) u_slots (
    .clk, .wr_en(sw_en), .wr_addr(slot_r), .wr_taken(sw_taken),
    .rd_addr(s_rd_addr), .rd_taken(s_rd_taken)
  );

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  // Job store writes during loading.
  assign jw_en   = in_acc && (fill_r < FW'(MAX_JOBS));
  assign jw_addr = fill_r[JAW-1:0];
  assign jw_data = '{deadline: in_deadline, profit: in_job_profit};
  assign jr_addr = scan_r[JAW-1:0];

  // Ordering keys: profit first, store index breaks ties.
  assign rkey = {jr_data.profit, raddr_r};
  assign bkey = {best_r.profit, best_idx_r};

  // Saturated deadline of the chosen job.
  always_comb begin
    if (32'(best_r.deadline) > 32'(MAX_DEADLINE)) dl_sat = DL_W'(MAX_DEADLINE);
    else dl_sat = best_r.deadline;
  end

  // Slot map: cleared at the start of a run, then marked as jobs are placed.
  assign s_rd_addr = slot_r;
  assign sw_taken  = (state_r == ST_SCHK);
  assign sw_en = (state_r == ST_CLR) ||
                 ((state_r == ST_SCHK) && !s_rd_taken && (slot_r != '0));

  // Control sequencer.
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; ovf_nxt = ovf_r; drop_nxt = drop_r;
    lim_ok_nxt = lim_ok_r; lim_nxt = lim_r; scan_nxt = scan_r; picks_nxt = picks_r;
    rvld_nxt = 1'b0; raddr_nxt = raddr_r;
    best_ok_nxt = best_ok_r; best_idx_nxt = best_idx_r; best_nxt = best_r;
    slot_nxt = slot_r; cnt_nxt = cnt_r; sum_nxt = sum_r;
    ovld_nxt = ovld_r; ocnt_nxt = ocnt_r; osum_nxt = osum_r; odrop_nxt = odrop_r;

    if (ovld_r && !out_stall) ovld_nxt = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (jw_en) fill_nxt = fill_r + FW'(1);
          else ovf_nxt = 1'b1;
          if (in_last) begin
            if (!jw_en) drop_nxt = 1'b1;
            else drop_nxt = ovf_r;
            lim_ok_nxt = 1'b0; picks_nxt = '0; cnt_nxt = '0; sum_nxt = '0;
            scan_nxt = '0; best_ok_nxt = 1'b0; slot_nxt = '0;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        // Clear one slot entry per cycle.
        slot_nxt = slot_r + SAW'(1);
        if (slot_r == SAW'(MAX_DEADLINE)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue one read per cycle, compare the data of the previous read.
        if (rvld_r && (!lim_ok_r || rkey < lim_r) &&
            (!best_ok_r || rkey > bkey)) begin
          best_ok_nxt = 1'b1; best_nxt = jr_data; best_idx_nxt = raddr_r;
        end
        if (picks_r == fill_r) begin
          state_nxt = ST_DONE;
        end else if (scan_r < fill_r) begin
          rvld_nxt = 1'b1; raddr_nxt = scan_r[JAW-1:0];
          scan_nxt = scan_r + FW'(1);
        end else if (!rvld_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        lim_ok_nxt = 1'b1; lim_nxt = bkey;
        picks_nxt = picks_r + FW'(1);
        slot_nxt = SAW'(dl_sat);
        state_nxt = (dl_sat == '0) ? ST_SCAN : ST_SLOT;
        scan_nxt = '0; best_ok_nxt = 1'b0;
      end
      ST_SLOT: begin
        // Wait for the slot read.
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (slot_r == '0) begin
          state_nxt = ST_SCAN;
        end else if (!s_rd_taken) begin
          if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + COUNT_W'(1);
          if ({1'b0, sum_r} + (SUM_W+1)'(best_r.profit) > (SUM_W+1)'(SUM_MAX))
            sum_nxt = SUM_MAX;
          else sum_nxt = sum_r + SUM_W'(best_r.profit);
          state_nxt = ST_SCAN;
        end else begin
          slot_nxt = slot_r - SAW'(1);
          state_nxt = (slot_r == SAW'(1)) ? ST_SCAN : ST_SLOT;
        end
      end
      ST_DONE: begin
        if (!ovld_r) begin
          ovld_nxt = 1'b1; ocnt_nxt = cnt_r; osum_nxt = sum_r; odrop_nxt = drop_r;
          fill_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; fill_r <= '0; ovf_r <= 1'b0; ovld_r <= 1'b0;
      rvld_r <= 1'b0; picks_r <= '0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; ovf_r <= ovf_nxt; ovld_r <= ovld_nxt;
      rvld_r <= rvld_nxt; picks_r <= picks_nxt;
    end
  end

  // Datapath registers; each is loaded before a run reads it.
  always_ff @(posedge clk) begin
    drop_r <= drop_nxt; lim_ok_r <= lim_ok_nxt; lim_r <= lim_nxt;
    scan_r <= scan_nxt; raddr_r <= raddr_nxt;
    best_ok_r <= best_ok_nxt; best_idx_r <= best_idx_nxt; best_r <= best_nxt;
    slot_r <= slot_nxt; cnt_r <= cnt_nxt; sum_r <= sum_nxt;
    ocnt_r <= ocnt_nxt; osum_r <= osum_nxt; odrop_r <= odrop_nxt;
  end

  assign out_valid           = ovld_r;
  assign out_scheduled_count = ocnt_r;
  assign out_total_profit    = osum_r;
  assign out_dropped         = odrop_r;

endmodule

FILE: sv/djs_checker.sv
// Port-level checks for the scheduler.
module djs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_scheduled_count,
  input logic [23:0] out_total_profit
);
  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_profit))
    else $error("stalled result changed");

  // A last request stops intake while the set is scheduled.
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken after last");

  // Zero jobs placed means zero profit.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scheduled_count == 8'd0 |-> out_total_profit == 24'd0)
    else $error("profit without jobs");
endmodule

bind deadline_job_scheduler_unit djs_checker u_djs_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_last, .out_valid, .out_stall,
  .out_scheduled_count, .out_total_profit
);
